FILE: design/fsl_pkg.sv
// Types, constants, saturation helper and the microcode program of the face slope limiter.
package fsl_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int FLOOR_W = 16;
  localparam int MUL_W = WORD_W + 1;
  localparam int WIDE_W = 2 * MUL_W;
  localparam int ACC_W = WIDE_W - FRAC_W;
  localparam int QUO_W = 2 * FRAC_W;
  localparam int DIV_W = 2 * WORD_W + 1;
  localparam int CNT_W = $clog2(QUO_W);
  localparam int PC_W = 5;
  localparam int CIDX_W = 1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [2:0][WORD_W-1:0] vec_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [1:0] MODE_LOAD_FACE = 2'd0;
  localparam logic [1:0] MODE_LOAD_CENTRES = 2'd1;
  localparam logic [1:0] MODE_LIMIT = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_LIMITER_KIND = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_SLOPE_FLOOR = 1'd1;

  localparam logic [2:0] A_GL = 3'd0;
  localparam logic [2:0] A_GR = 3'd1;
  localparam logic [2:0] A_VL = 3'd2;
  localparam logic [2:0] A_VR = 3'd3;
  localparam logic [2:0] A_R = 3'd4;
  localparam logic [2:0] A_Q = 3'd5;

  localparam logic [2:0] B_NRM = 3'd0;
  localparam logic [2:0] B_OFL = 3'd1;
  localparam logic [2:0] B_OFR = 3'd2;
  localparam logic [2:0] B_R = 3'd3;
  localparam logic [2:0] B_DOTL = 3'd4;
  localparam logic [2:0] B_DOTR = 3'd5;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD = 2'd2;

  localparam logic [3:0] OP_NOP = 4'd0;
  localparam logic [3:0] OP_WR_SL = 4'd1;
  localparam logic [3:0] OP_WR_SR = 4'd2;
  localparam logic [3:0] OP_WR_DOTL = 4'd3;
  localparam logic [3:0] OP_WR_DOTR = 4'd4;
  localparam logic [3:0] OP_FLAGS = 4'd5;
  localparam logic [3:0] OP_DIV_R = 4'd6;
  localparam logic [3:0] OP_LOAD_R = 4'd7;
  localparam logic [3:0] OP_DIV_PHI = 4'd8;
  localparam logic [3:0] OP_DELTA_L = 4'd9;
  localparam logic [3:0] OP_DELTA_R = 4'd10;
  localparam logic [3:0] OP_MM_DELTA = 4'd11;
  localparam logic [3:0] OP_OUT = 4'd12;

  localparam logic [2:0] J_NEXT = 3'd0;
  localparam logic [2:0] J_GOTO = 3'd1;
  localparam logic [2:0] J_SKIP = 3'd2;
  localparam logic [2:0] J_MINMOD = 3'd3;
  localparam logic [2:0] J_DIVWAIT = 3'd4;
  localparam logic [2:0] J_END = 3'd5;

  localparam logic [PC_W-1:0] STEP_MM = 5'd26;
  localparam logic [PC_W-1:0] STEP_OUT = 5'd27;

  typedef struct packed {
    logic [2:0] src_a;
    logic [2:0] src_b;
    logic [1:0] comp;
    logic mul_en;
    logic [1:0] acc_op;
    logic [3:0] op;
    logic [2:0] jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic skip;
    logic minmod;
    logic div_busy;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic minmod;
    logic [FLOOR_W-1:0] slope_floor;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    word_t sol_left;
    word_t sol_right;
    vec_t vec_a;
    vec_t vec_b;
  } in_item_t;

  typedef struct packed {
    word_t sol_left;
    word_t sol_right;
    logic was_limited;
  } res_t;

  function automatic word_t sat_word(input wide_t v);
    logic all0;
    logic all1;
    all0 = ~|v[WIDE_W-1:WORD_W-1];
    all1 = &v[WIDE_W-1:WORD_W-1];
    if (all0 || all1) begin
      return v[WORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return WORD_MIN;
    end else begin
      return WORD_MAX;
    end
  endfunction

  function automatic ctrl_t cw(input logic [2:0] src_a, input logic [2:0] src_b,
                               input logic [1:0] comp, input logic mul_en,
                               input logic [1:0] acc_op, input logic [3:0] op,
                               input logic [2:0] jmp, input logic [PC_W-1:0] target);
    ctrl_t w;
    w.src_a = src_a;
    w.src_b = src_b;
    w.comp = comp;
    w.mul_en = mul_en;
    w.acc_op = acc_op;
    w.op = op;
    w.jmp = jmp;
    w.target = target;
    return w;
  endfunction

  localparam ctrl_t NOP_WORD = '0;

  // Each dot product issues one product a step and folds the previous product into the sum.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0: w = cw(A_GL, B_NRM, 2'd0, 1'b1, ACC_HOLD, OP_NOP, J_NEXT, '0);
      5'd1: w = cw(A_GL, B_NRM, 2'd1, 1'b1, ACC_LOAD, OP_NOP, J_NEXT, '0);
      5'd2: w = cw(A_GL, B_NRM, 2'd2, 1'b1, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd3: w = cw(A_GR, B_NRM, 2'd0, 1'b1, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd4: w = cw(A_GR, B_NRM, 2'd1, 1'b1, ACC_LOAD, OP_WR_SL, J_NEXT, '0);
      5'd5: w = cw(A_GR, B_NRM, 2'd2, 1'b1, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd6: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd7: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_WR_SR, J_NEXT, '0);
      5'd8: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_FLAGS, J_NEXT, '0);
      5'd9: w = cw(A_VL, B_OFL, 2'd0, 1'b1, ACC_HOLD, OP_NOP, J_SKIP, STEP_OUT);
      5'd10: w = cw(A_VL, B_OFL, 2'd1, 1'b1, ACC_LOAD, OP_NOP, J_NEXT, '0);
      5'd11: w = cw(A_VL, B_OFL, 2'd2, 1'b1, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd12: w = cw(A_VR, B_OFR, 2'd0, 1'b1, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd13: w = cw(A_VR, B_OFR, 2'd1, 1'b1, ACC_LOAD, OP_WR_DOTL, J_NEXT, '0);
      5'd14: w = cw(A_VR, B_OFR, 2'd2, 1'b1, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd15: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_ADD, OP_NOP, J_NEXT, '0);
      5'd16: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_WR_DOTR, J_MINMOD, STEP_MM);
      5'd17: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_DIV_R, J_NEXT, '0);
      5'd18: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_NOP, J_DIVWAIT, '0);
      5'd19: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_LOAD_R, J_NEXT, '0);
      5'd20: w = cw(A_R, B_R, 2'd0, 1'b1, ACC_HOLD, OP_NOP, J_NEXT, '0);
      5'd21: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_DIV_PHI, J_NEXT, '0);
      5'd22: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_NOP, J_DIVWAIT, '0);
      5'd23: w = cw(A_Q, B_DOTL, 2'd0, 1'b1, ACC_HOLD, OP_NOP, J_NEXT, '0);
      5'd24: w = cw(A_Q, B_DOTR, 2'd0, 1'b1, ACC_HOLD, OP_DELTA_L, J_NEXT, '0);
      5'd25: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_DELTA_R, J_GOTO, STEP_OUT);
      5'd26: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_MM_DELTA, J_NEXT, '0);
      5'd27: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_OUT, J_END, '0);
      default: w = cw(A_GL, B_NRM, 2'd0, 1'b0, ACC_HOLD, OP_NOP, J_END, '0);
    endcase
    return w;
  endfunction

endpackage

FILE: design/fsl_if.sv
// Input and result channel interfaces of the face slope limiter.
interface fsl_in_if import fsl_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] mode;
  word_t sol_left_in;
  word_t sol_right_in;
  word_t vec_a_x;
  word_t vec_a_y;
  word_t vec_a_z;
  word_t vec_b_x;
  word_t vec_b_y;
  word_t vec_b_z;

  modport source(output valid, mode, sol_left_in, sol_right_in, vec_a_x, vec_a_y, vec_a_z,
                 vec_b_x, vec_b_y, vec_b_z, input ready);
  modport sink(input valid, mode, sol_left_in, sol_right_in, vec_a_x, vec_a_y, vec_a_z,
               vec_b_x, vec_b_y, vec_b_z, output ready);
endinterface

interface fsl_out_if import fsl_pkg::*; ();
  logic valid;
  logic ready;
  word_t sol_left_out;
  word_t sol_right_out;
  logic was_limited;

  modport source(output valid, sol_left_out, sol_right_out, was_limited, input ready);
  modport sink(input valid, sol_left_out, sol_right_out, was_limited, output ready);
endinterface

FILE: design/face_slope_limiter.sv
// Face slope limiter top level: configuration registers, handshakes, sequencer and datapath.
// One item at a time. Load items (normal/point, centres) and unused codes do not start the sequencer.
// A limit item's time from transfer to result is set with Van Albada by the two passes of
// the shared divider; it is shorter with minmod and shortest when skipped.
// The result waits in an output register; the next item is taken while it waits.
// Synchronous reset clears face state to zero, limiter_kind to 0 and slope_floor to 1.
module face_slope_limiter import fsl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [FLOOR_W-1:0] cfg_data,
  fsl_in_if.sink item,
  fsl_out_if.source result
);

  logic limiter_kind;
  logic [FLOOR_W-1:0] slope_floor;
  logic take;
  logic seq_busy;
  in_item_t item_data;
  cfg_t cfg;
  ctrl_t ctrl;
  status_t status;
  res_t res;
  logic res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_kind <= 1'b0;
      slope_floor <= FLOOR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIMITER_KIND: limiter_kind <= cfg_data[0];
        CFG_SLOPE_FLOOR: slope_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.minmod = limiter_kind;
  assign cfg.slope_floor = slope_floor;

  assign item.ready = !seq_busy;
  assign take = item.valid && item.ready;

  assign item_data.mode = item.mode;
  assign item_data.sol_left = item.sol_left_in;
  assign item_data.sol_right = item.sol_right_in;
  assign item_data.vec_a = {item.vec_a_z, item.vec_a_y, item.vec_a_x};
  assign item_data.vec_b = {item.vec_b_z, item.vec_b_y, item.vec_b_x};

  fsl_seq u_seq (
    .clk(clk),
    .rst(rst),
    .start(take && item.mode == MODE_LIMIT),
    .status(status),
    .ctrl(ctrl),
    .busy(seq_busy)
  );

  fsl_dp u_dp (
    .clk(clk),
    .rst(rst),
    .take(take),
    .item_data(item_data),
    .cfg(cfg),
    .ctrl(ctrl),
    .out_ready(result.ready),
    .status(status),
    .out_valid(res_valid),
    .res(res)
  );

  assign result.valid = res_valid;
  assign result.sol_left_out = res.sol_left;
  assign result.sol_right_out = res.sol_right;
  assign result.was_limited = res.was_limited;

endmodule

FILE: design/fsl_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module fsl_div import fsl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [DIV_W-1:0] rem_init,
  input  logic [QUO_W-1:0] low_bits,
  input  logic [DIV_W-1:0] divisor,
  output logic busy,
  output logic [QUO_W-1:0] quot
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [QUO_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic ge;

  assign shifted = {rem, shreg[QUO_W-1]};
  assign diff = shifted - {1'b0, dsr};
  assign ge = ~diff[DIV_W];
  assign quot = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dsr <= divisor;
      shreg <= low_bits;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      shreg <= {shreg[QUO_W-2:0], ge};
    end
  end

endmodule

FILE: design/fsl_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module fsl_seq import fsl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  status_t status,
  output ctrl_t ctrl,
  output logic busy
);

  logic [PC_W-1:0] pc;
  ctrl_t word;

  assign word = ucode(pc);
  assign ctrl = busy ? word : NOP_WORD;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc <= '0;
      end
    end else begin
      unique case (word.jmp)
        J_NEXT: pc <= pc + 1'b1;
        J_GOTO: pc <= word.target;
        J_SKIP: pc <= status.skip ? word.target : pc + 1'b1;
        J_MINMOD: pc <= status.minmod ? word.target : pc + 1'b1;
        J_DIVWAIT: begin
          if (!status.div_busy) begin
            pc <= pc + 1'b1;
          end
        end
        J_END: begin
          if (status.out_free) begin
            busy <= 1'b0;
          end
        end
        default: pc <= pc + 1'b1;
      endcase
    end
  end

endmodule

FILE: design/fsl_dp.sv
// Datapath: face state, shared multiplier, accumulator, divider and result register.
module fsl_dp import fsl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  in_item_t item_data,
  input  cfg_t cfg,
  input  ctrl_t ctrl,
  input  logic out_ready,
  output status_t status,
  output logic out_valid,
  output res_t res
);

  word_t face_normal [3];
  word_t face_point [3];
  word_t offset_left [3];
  word_t offset_right [3];
  word_t grad_l [3];
  word_t grad_r [3];
  word_t off_l_next [3];
  word_t off_r_next [3];
  word_t sol_l;
  word_t sol_r;
  word_t sl;
  word_t sr;
  word_t dotl;
  word_t dotr;
  word_t dl;
  word_t dr;
  word_t dl_eff;
  word_t dr_eff;
  logic [WORD_W-1:0] magl;
  logic [WORD_W-1:0] magr;
  logic [WORD_W-1:0] magl_c;
  logic [WORD_W-1:0] magr_c;
  logic skip;
  logic minmod;
  logic sel_l_gr;
  logic sel_r_gl;
  logic rzero;
  logic rclamp;
  logic [QUO_W-1:0] r_val;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  wide_t prod;
  logic signed [ACC_W-1:0] acc;
  logic [DIV_W-1:0] num;
  logic [DIV_W-1:0] den;
  logic div_start;
  logic [DIV_W-1:0] div_rem;
  logic [QUO_W-1:0] div_low;
  logic [DIV_W-1:0] div_dsr;
  logic div_busy;
  logic [QUO_W-1:0] quot;
  logic out_free;
  logic signed [WORD_W:0] sum_l;
  logic signed [WORD_W:0] sum_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_l_next[i] = sat_word(WIDE_W'((WORD_W+1)'(face_point[i])
                                       - (WORD_W+1)'(word_t'(item_data.vec_a[i]))));
      off_r_next[i] = sat_word(WIDE_W'((WORD_W+1)'(face_point[i])
                                       - (WORD_W+1)'(word_t'(item_data.vec_b[i]))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        face_normal[i] <= '0;
        face_point[i] <= '0;
        offset_left[i] <= '0;
        offset_right[i] <= '0;
      end
    end else if (take) begin
      unique case (item_data.mode)
        MODE_LOAD_FACE: begin
          for (int i = 0; i < 3; i++) begin
            face_normal[i] <= item_data.vec_a[i];
            face_point[i] <= item_data.vec_b[i];
          end
        end
        MODE_LOAD_CENTRES: begin
          for (int i = 0; i < 3; i++) begin
            offset_left[i] <= off_l_next[i];
            offset_right[i] <= off_r_next[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_data.mode == MODE_LIMIT) begin
      for (int i = 0; i < 3; i++) begin
        grad_l[i] <= item_data.vec_a[i];
        grad_r[i] <= item_data.vec_b[i];
      end
      sol_l <= item_data.sol_left;
      sol_r <= item_data.sol_right;
    end
  end

  always_comb begin
    unique case (ctrl.src_a)
      A_GL: mul_a = MUL_W'(grad_l[ctrl.comp]);
      A_GR: mul_a = MUL_W'(grad_r[ctrl.comp]);
      A_VL: mul_a = MUL_W'(sel_l_gr ? grad_r[ctrl.comp] : grad_l[ctrl.comp]);
      A_VR: mul_a = MUL_W'(sel_r_gl ? grad_l[ctrl.comp] : grad_r[ctrl.comp]);
      A_R: mul_a = {1'b0, r_val};
      A_Q: mul_a = {1'b0, quot};
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.src_b)
      B_NRM: mul_b = MUL_W'(face_normal[ctrl.comp]);
      B_OFL: mul_b = MUL_W'(offset_left[ctrl.comp]);
      B_OFR: mul_b = MUL_W'(offset_right[ctrl.comp]);
      B_R: mul_b = {1'b0, r_val};
      B_DOTL: mul_b = MUL_W'(dotl);
      B_DOTR: mul_b = MUL_W'(dotr);
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (ctrl.acc_op)
      ACC_LOAD: acc <= prod[WIDE_W-1:FRAC_W];
      ACC_ADD: acc <= acc + prod[WIDE_W-1:FRAC_W];
      default: ;
    endcase
  end

  assign magl_c = sl[WORD_W-1] ? (~sl + 1'b1) : sl;
  assign magr_c = sr[WORD_W-1] ? (~sr + 1'b1) : sr;

  assign num = {1'b0, prod[2*WORD_W-1:0]} + (DIV_W'(r_val) << FRAC_W);
  assign den = (DIV_W'(1) << (2 * FRAC_W)) + {1'b0, prod[2*WORD_W-1:0]};

  assign div_start = (ctrl.op == OP_DIV_R) || (ctrl.op == OP_DIV_PHI);

  always_comb begin
    if (ctrl.op == OP_DIV_PHI) begin
      div_rem = num >> (FRAC_W + 1);
      div_low = {num[FRAC_W:0], (FRAC_W - 1)'(0)};
      div_dsr = den;
    end else begin
      div_rem = DIV_W'(magr[WORD_W-1:FRAC_W]);
      div_low = {magr[FRAC_W-1:0], FRAC_W'(0)};
      div_dsr = DIV_W'(magl);
    end
  end

  fsl_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .rem_init(div_rem),
    .low_bits(div_low),
    .divisor(div_dsr),
    .busy(div_busy),
    .quot(quot)
  );

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_WR_SL: sl <= sat_word(WIDE_W'(acc));
      OP_WR_SR: sr <= sat_word(WIDE_W'(acc));
      OP_WR_DOTL: dotl <= sat_word(WIDE_W'(acc));
      OP_WR_DOTR: dotr <= sat_word(WIDE_W'(acc));
      OP_FLAGS: begin
        magl <= magl_c;
        magr <= magr_c;
        minmod <= cfg.minmod;
        if (cfg.minmod) begin
          skip <= (sl < 0 && sr > 0) || (sl > 0 && sr < 0);
        end else begin
          skip <= (sl == 0) || (magl_c < WORD_W'(cfg.slope_floor));
        end
        sel_l_gr <= cfg.minmod && (magl_c > magr_c);
        sel_r_gl <= cfg.minmod && (magl_c < magr_c);
        rzero <= (sr == 0) || (sl[WORD_W-1] != sr[WORD_W-1]);
        rclamp <= WORD_W'(magr_c[WORD_W-1:FRAC_W]) >= magl_c;
      end
      OP_LOAD_R: begin
        if (rzero) begin
          r_val <= '0;
        end else if (rclamp) begin
          r_val <= '1;
        end else begin
          r_val <= quot;
        end
      end
      OP_DELTA_L: dl <= sat_word(prod >>> FRAC_W);
      OP_DELTA_R: dr <= sat_word(prod >>> FRAC_W);
      OP_MM_DELTA: begin
        dl <= dotl >>> 1;
        dr <= dotr >>> 1;
      end
      default: ;
    endcase
  end

  always_comb begin
    dl_eff = dl;
    dr_eff = dr;
    if (skip) begin
      dl_eff = '0;
      dr_eff = '0;
    end
  end

  assign sum_l = (WORD_W+1)'(sol_l) + (WORD_W+1)'(dl_eff);
  assign sum_r = (WORD_W+1)'(sol_r) + (WORD_W+1)'(dr_eff);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_OUT && out_free) begin
      res.sol_left <= sat_word(WIDE_W'(sum_l));
      res.sol_right <= sat_word(WIDE_W'(sum_r));
      res.was_limited <= !skip;
    end
  end

  assign status.skip = skip;
  assign status.minmod = minmod;
  assign status.div_busy = div_busy;
  assign status.out_free = out_free;

endmodule

FILE: sim/face_slope_limiter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for face_slope_limiter: random ready/valid traffic against a predictor.
module face_slope_limiter_tb;
  import fsl_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [FLOOR_W-1:0] KIND_VAN_ALBADA = 16'd0;
  localparam logic [FLOOR_W-1:0] KIND_MINMOD = 16'd1;
  localparam word_t UNIT = 32'sd65536;
  localparam logic [63:0] RATIO_CAP = (64'd1 << (FRAC_W + 16)) - 64'd1;
  localparam int unsigned LONG_HOLD = 600;

  typedef struct packed {
    logic [1:0] mode;
    word_t sol_l, sol_r, ax, ay, az, bx, by, bz;
  } face_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [FLOOR_W-1:0] cfg_data = '0;
  logic send_valid = 1'b0;
  face_item_t send_item = '0;
  logic recv_ready = 1'b0;
  logic send_idle = 1'b1;
  logic recv_idle = 1'b1;
  logic long_hold_done = 1'b0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int results_seen = 0;
  int mismatches = 0;

  // Predictor copy of the face state and the configuration.
  vec_t face_nrm = '0;
  vec_t face_pnt = '0;
  vec_t face_ofl = '0;
  vec_t face_ofr = '0;
  logic minmod_sel = 1'b0;
  logic [FLOOR_W-1:0] floor_sel = 16'd1;

  face_item_t face_items_queued[$];
  res_t limited_values_due[$];

  fsl_in_if item_ch();
  fsl_out_if result_ch();

  assign item_ch.valid = send_valid;
  assign item_ch.mode = send_item.mode;
  assign item_ch.sol_left_in = send_item.sol_l;
  assign item_ch.sol_right_in = send_item.sol_r;
  assign item_ch.vec_a_x = send_item.ax;
  assign item_ch.vec_a_y = send_item.ay;
  assign item_ch.vec_a_z = send_item.az;
  assign item_ch.vec_b_x = send_item.bx;
  assign item_ch.vec_b_y = send_item.by;
  assign item_ch.vec_b_z = send_item.bz;
  assign result_ch.ready = recv_ready;

  face_slope_limiter u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item_ch),
    .result(result_ch)
  );

  always #2 clk = ~clk;

  function automatic word_t clip_word(input longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  function automatic longint abs_of(input word_t v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic word_t dot3(input vec_t a, input vec_t b);
    longint acc;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      acc += (longint'($signed(a[i])) * longint'($signed(b[i]))) >>> FRAC_W;
    end
    return clip_word(acc);
  endfunction

  function automatic void predict_limited_values(input face_item_t it);
    vec_t ga, gb, gsl, gsr;
    word_t sl, sr, dl, dr;
    longint weight;
    logic [63:0] ratio;
    logic [127:0] r, rsq, num, den;
    res_t want;
    ga = {it.az, it.ay, it.ax};
    gb = {it.bz, it.by, it.bx};
    case (it.mode)
      MODE_LOAD_FACE: begin
        face_nrm = ga;
        face_pnt = gb;
      end
      MODE_LOAD_CENTRES: begin
        for (int i = 0; i < 3; i++) begin
          face_ofl[i] = clip_word(longint'($signed(face_pnt[i])) - longint'($signed(ga[i])));
          face_ofr[i] = clip_word(longint'($signed(face_pnt[i])) - longint'($signed(gb[i])));
        end
      end
      MODE_LIMIT: begin
        sl = dot3(ga, face_nrm);
        sr = dot3(gb, face_nrm);
        want.sol_left = it.sol_l;
        want.sol_right = it.sol_r;
        want.was_limited = 1'b0;
        if (!minmod_sel) begin
          if (sl != 0 && abs_of(sl) >= longint'(floor_sel)) begin
            weight = 0;
            if (sr != 0 && ((sl < 0) == (sr < 0))) begin
              ratio = abs_of(sr);
              ratio = (ratio << FRAC_W) / abs_of(sl);
              if (ratio > RATIO_CAP) ratio = RATIO_CAP;
              if (ratio != 0) begin
                r = {64'd0, ratio};
                rsq = r * r;
                num = rsq + (r << FRAC_W);
                den = (128'd1 << (2 * FRAC_W)) + rsq;
                r = (num << FRAC_W) / (den << 1);
                weight = longint'(r[63:0]);
              end
            end
            dl = clip_word((weight * longint'(dot3(ga, face_ofl))) >>> FRAC_W);
            dr = clip_word((weight * longint'(dot3(gb, face_ofr))) >>> FRAC_W);
            want.sol_left = clip_word(longint'(it.sol_l) + longint'(dl));
            want.sol_right = clip_word(longint'(it.sol_r) + longint'(dr));
            want.was_limited = 1'b1;
          end
        end else if (!((sl < 0 && sr > 0) || (sl > 0 && sr < 0))) begin
          gsl = ga;
          gsr = gb;
          if (abs_of(sl) < abs_of(sr)) gsr = ga;
          else if (abs_of(sl) > abs_of(sr)) gsl = gb;
          dl = clip_word(longint'(dot3(gsl, face_ofl)) >>> 1);
          dr = clip_word(longint'(dot3(gsr, face_ofr)) >>> 1);
          want.sol_left = clip_word(longint'(it.sol_l) + longint'(dl));
          want.sol_right = clip_word(longint'(it.sol_r) + longint'(dr));
          want.was_limited = 1'b1;
        end
        limited_values_due.push_back(want);
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic word_t rand_word();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return word_t'($urandom);
    if (roll == 2) begin
      case ($urandom_range(0, 4))
        0: return WORD_MAX;
        1: return WORD_MIN;
        2: return 32'sd0;
        3: return 32'sd1;
        default: return -32'sd1;
      endcase
    end
    return word_t'(int'($urandom_range(0, 1048576)) - 524288);
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_face_item(input logic [1:0] m,
                                 input word_t sl, sr, ax, ay, az, bx, by, bz);
    face_item_t it;
    it.mode = m;
    it.sol_l = sl;
    it.sol_r = sr;
    it.ax = ax;
    it.ay = ay;
    it.az = az;
    it.bx = bx;
    it.by = by;
    it.bz = bz;
    face_items_queued.push_back(it);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [FLOOR_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LIMITER_KIND) minmod_sel = value[0];
    else floor_sel = value;
  endtask

  // Returns once every queued item has been taken and every predicted result has come back.
  task automatic settle();
    do @(negedge clk);
    while (face_items_queued.size() != 0 || send_valid || limited_values_due.size() != 0);
    repeat (16) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (send_valid && item_ch.ready) predict_limited_values(send_item);
      if (!send_valid || item_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          send_valid <= 1'b0;
        end else if (face_items_queued.size() != 0) begin
          send_item <= face_items_queued.pop_front();
          send_valid <= 1'b1;
          send_gap <= send_idle ? draw_gap() : 0;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    int unsigned stall;
    res_t want;
    if (rst) begin
      recv_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (result_ch.valid && recv_ready) begin
        results_seen++;
        if (limited_values_due.size() == 0) begin
          flag_mismatch("unexpected result, sol_left_out", result_ch.sol_left_out, 0);
        end else begin
          want = limited_values_due.pop_front();
          if (result_ch.sol_left_out !== want.sol_left)
            flag_mismatch("sol_left_out", result_ch.sol_left_out, want.sol_left);
          if (result_ch.sol_right_out !== want.sol_right)
            flag_mismatch("sol_right_out", result_ch.sol_right_out, want.sol_right);
          if (result_ch.was_limited !== want.was_limited)
            flag_mismatch("was_limited", result_ch.was_limited, want.was_limited);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        recv_ready <= 1'b0;
      end else if (results_seen >= 120 && !long_hold_done) begin
        // Hold the result back long enough for the block to fill and stop taking items.
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD - 1;
        recv_ready <= 1'b0;
      end else begin
        stall = (recv_idle && $urandom_range(0, 3) == 0) ? draw_gap() : 0;
        recv_ready <= (stall == 0);
        hold_left <= (stall == 0) ? 0 : stall - 1;
      end
    end
  end

  initial begin : stimulus
    int made;
    logic [1:0] m;
    word_t gx, gy, gz, hx, hy, hz;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Van Albada with the reset floor.
    @(negedge clk);
    queue_face_item(MODE_LOAD_FACE, 0, 0, UNIT, 0, 0, 2 * UNIT, UNIT, -UNIT);
    queue_face_item(MODE_LOAD_CENTRES, 0, 0, 0, 0, 0, 4 * UNIT, 3 * UNIT, 0);
    queue_face_item(MODE_LIMIT, UNIT, -UNIT, UNIT, UNIT, 0, 2 * UNIT, 0, 0);
    queue_face_item(MODE_LIMIT, 3 * UNIT, 0, 0, 5, 5, UNIT, 0, 0);
    queue_face_item(MODE_LIMIT, -UNIT, UNIT, -UNIT, 0, 0, UNIT, UNIT, 0);
    queue_face_item(MODE_LIMIT, WORD_MAX, WORD_MIN, 1, WORD_MAX, 0, WORD_MAX, 0, WORD_MIN);
    queue_face_item(MODE_UNUSED, word_t'($urandom), word_t'($urandom), word_t'($urandom),
                    word_t'($urandom), word_t'($urandom), word_t'($urandom),
                    word_t'($urandom), word_t'($urandom));
    queue_face_item(MODE_LOAD_FACE, 0, 0, WORD_MAX, WORD_MIN, WORD_MAX,
                    WORD_MIN, WORD_MAX, WORD_MIN);
    queue_face_item(MODE_LOAD_CENTRES, 0, 0, WORD_MAX, WORD_MIN, 0, WORD_MIN, WORD_MAX, WORD_MIN);
    queue_face_item(MODE_LIMIT, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                    WORD_MIN, WORD_MIN, WORD_MIN);
    queue_face_item(MODE_LOAD_FACE, 0, 0, UNIT, 0, 0, 0, 0, 0);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, UNIT, 0, UNIT, UNIT / 2, UNIT, 0);

    settle();
    write_reg(CFG_SLOPE_FLOOR, 16'hFFFF);
    @(negedge clk);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, 65534, 0, 0, UNIT, 0, 0);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, 65535, 0, 0, UNIT, 0, 0);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, -65535, 0, 0, -3 * UNIT, 0, 0);

    settle();
    write_reg(CFG_LIMITER_KIND, KIND_MINMOD);
    write_reg(CFG_SLOPE_FLOOR, 16'd0);
    @(negedge clk);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, UNIT, 0, 0, -UNIT, 0, 0);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, 0, UNIT, 0, UNIT, 0, 0);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, UNIT, 2 * UNIT, 0, 3 * UNIT, -UNIT, 0);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, -4 * UNIT, UNIT, 0, -UNIT, 0, UNIT);
    queue_face_item(MODE_LIMIT, UNIT, UNIT, 2 * UNIT, 5 * UNIT, 0, 2 * UNIT, -7 * UNIT, 3);
    queue_face_item(MODE_LIMIT, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, 0, WORD_MAX, 0, 0);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CFG_LIMITER_KIND, KIND_VAN_ALBADA);
          write_reg(CFG_SLOPE_FLOOR, 16'd1);
        end
        1: begin
          write_reg(CFG_LIMITER_KIND, KIND_VAN_ALBADA);
          write_reg(CFG_SLOPE_FLOOR, 16'd0);
        end
        2: begin
          write_reg(CFG_LIMITER_KIND, KIND_MINMOD);
          write_reg(CFG_SLOPE_FLOOR, 16'($urandom));
        end
        3: begin
          write_reg(CFG_LIMITER_KIND, KIND_VAN_ALBADA);
          write_reg(CFG_SLOPE_FLOOR, 16'hFFFF);
        end
        4: begin
          write_reg(CFG_LIMITER_KIND, KIND_VAN_ALBADA);
          write_reg(CFG_SLOPE_FLOOR, 16'($urandom_range(2, 300)));
        end
        default: begin
          write_reg(CFG_LIMITER_KIND, KIND_MINMOD);
          write_reg(CFG_SLOPE_FLOOR, 16'd1);
        end
      endcase
      @(negedge clk);
      send_idle <= (p != 1 && p != 3);
      recv_idle <= (p != 2 && p != 3);
      made = 0;
      while (made < 260) begin
        if ($urandom_range(0, 99) < 8) begin
          m = 2'($urandom_range(0, 3));
          queue_face_item(m, word_t'($urandom), word_t'($urandom), word_t'($urandom),
                          word_t'($urandom), word_t'($urandom), word_t'($urandom),
                          word_t'($urandom), word_t'($urandom));
          if (m != MODE_UNUSED) made++;
        end else begin
          if ($urandom_range(0, 2) == 0) begin
            queue_face_item(MODE_LOAD_FACE, rand_word(), rand_word(), rand_word(), rand_word(),
                            rand_word(), rand_word(), rand_word(), rand_word());
            made++;
          end
          if ($urandom_range(0, 2) == 0) begin
            queue_face_item(MODE_LOAD_CENTRES, rand_word(), rand_word(), rand_word(),
                            rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
            made++;
          end
          repeat ($urandom_range(1, 5)) begin
            gx = rand_word();
            gy = rand_word();
            gz = rand_word();
            if ($urandom_range(0, 19) == 0) begin
              gx = 0;
              gy = 0;
              gz = 0;
            end
            // Related gradients give equal, opposite and proportional slopes.
            case ($urandom_range(0, 4))
              0: begin
                hx = gx;
                hy = gy;
                hz = gz;
              end
              1: begin
                hx = -gx;
                hy = -gy;
                hz = -gz;
              end
              2: begin
                hx = gx >>> 1;
                hy = gy >>> 1;
                hz = gz >>> 1;
              end
              default: begin
                hx = rand_word();
                hy = rand_word();
                hz = rand_word();
              end
            endcase
            queue_face_item(MODE_LIMIT, rand_word(), rand_word(), gx, gy, gz, hx, hy, hz);
            made++;
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
